FILE: hw/rtl/ddr_pkg.sv
// Shared types and constants for the differential drive ramp generator.
// Used by the top level; no dependencies of its own.
package ddr_pkg;

	localparam int PWR_W  = 11;
	localparam int MULT_W = 8;
	localparam int TIME_W = 15;
	localparam int CMD_W  = 3;

	typedef logic signed [PWR_W-1:0]  power_t;
	typedef logic signed [MULT_W-1:0] mult_t;
	typedef logic [TIME_W-1:0]        ticks_t;
	typedef logic [CMD_W-1:0]         cmd_t;

	// Command codes; the unused top code is treated as a stop.
	localparam cmd_t CMD_TICK  = 3'd0;
	localparam cmd_t CMD_FWD   = 3'd1;
	localparam cmd_t CMD_BACK  = 3'd2;
	localparam cmd_t CMD_LEFT  = 3'd3;
	localparam cmd_t CMD_RIGHT = 3'd4;
	localparam cmd_t CMD_BRAKE = 3'd5;
	localparam cmd_t CMD_STOP  = 3'd6;

	localparam int PCT_FULL  = 100;
	localparam int DRIVE_MAX = 1023;

	localparam mult_t  MULT_FWD   = 8'sd100;
	localparam mult_t  MULT_REV   = -8'sd100;
	localparam power_t DRIVE_HI   = 11'sd1023;
	localparam power_t DRIVE_LO   = -11'sd1023;

endpackage

FILE: hw/rtl/ddr_muldiv.sv
// Shared multiply-then-divide unit: q = trunc(a * b / d), one quotient bit per cycle.
// Standalone; used by differential_drive_ramp_core.
module ddr_muldiv #(
	parameter int AW = 12,
	parameter int BW = 16,
	parameter int DW = 15,
	parameter int QW = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	input  logic [DW-1:0]        d,
	output logic                 done,
	output logic signed [QW:0]   q
);

	localparam int PW    = AW + BW;
	localparam int CW    = (PW > DW + QW) ? PW : DW + QW;
	localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL  = 4'b0010,
		M_DIV  = 4'b0100,
		M_DONE = 4'b1000
	} md_state_t;

	md_state_t        state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    a_mag_q;
	logic [BW-1:0]    b_mag_q;
	logic             neg_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    dsh_q;
	logic [QW-1:0]    quo_q;
	logic [AW-1:0]    a_abs;
	logic [BW-1:0]    b_abs;
	logic [PW-1:0]    prod;
	logic             fits;

	assign a_abs = a[AW-1] ? AW'(-a) : AW'(a);
	assign b_abs = b[BW-1] ? BW'(-b) : BW'(b);
	assign prod  = a_mag_q * b_mag_q;
	assign fits  = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					state_q <= M_DIV;
					cnt_q   <= CNT_W'(QW - 1);
				end
				M_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= M_DONE;
					end
				end
				M_DONE: begin
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			a_mag_q <= a_abs;
			b_mag_q <= b_abs;
			neg_q   <= a[AW-1] ^ b[BW-1];
			dsh_q   <= CW'(d) << (QW - 1);
		end else if (state_q == M_MUL) begin
			rem_q <= CW'(prod);
		end else if (state_q == M_DIV) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QW-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = (state_q == M_DONE);
	assign q    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

FILE: hw/rtl/differential_drive_ramp_core.sv
// Top level of the differential drive ramp generator: sequencer and ramp state.
// Depends on ddr_pkg and ddr_muldiv.

// One word in gives one word out. A word carries a command in tuser (tick,
// forward, backward, turn left, turn right, brake, stop) with an amount and a
// duration in tdata; the result word gives both wheel drives and the ramping
// and rejected flags. Every product and quotient comes from one shared
// multiply-divide unit that settles one quotient bit per cycle; QW is 11
// at the default FULL_POWER and is the bit count of FULL_POWER above 2047.
// A tick during a ramp needs three interpolations and two drive products.
// A tick while idle needs the two drive products; a move command passes
// through S_SET before them, with one more operation for a turn from
// standstill, and a stop needs no operation.
// The input is ready only while the sequencer is idle; a finished result
// waits in the output register, so the next word can be taken before it is read.
module differential_drive_ramp_core #(
	parameter int FULL_POWER = 1023
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [31:0]    s_tdata,  // [10:0] amount, [25:11] duration, [31:26] zero
	input  ddr_pkg::cmd_t  s_tuser,  // [2:0] command
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [23:0]    m_tdata,  // [10:0] left_drive, [21:11] right_drive, [23:22] zero
	output logic [1:0]     m_tuser   // [0] ramping, [1] rejected
);
	import ddr_pkg::*;

	localparam int FP_BITS = $clog2(FULL_POWER + 1);
	localparam int AW      = (FP_BITS + 1 > PWR_W + 1) ? FP_BITS + 1 : PWR_W + 1;
	localparam int BW      = TIME_W + 1;
	localparam int DW      = TIME_W;
	localparam int QW      = (FP_BITS > PWR_W) ? FP_BITS : PWR_W;
	localparam int RW      = QW + 1;
	localparam int PWR_LIM = (FULL_POWER < DRIVE_MAX) ? FULL_POWER : DRIVE_MAX;

	localparam power_t            PWR_HI = power_t'(PWR_LIM);
	localparam power_t            PWR_LO = -power_t'(PWR_LIM);
	localparam logic signed [RW-1:0] Q_HI = RW'(DRIVE_MAX);
	localparam logic signed [RW-1:0] Q_LO = -RW'(DRIVE_MAX);
	localparam power_t            SPD_HI = power_t'(PCT_FULL);
	localparam power_t            SPD_LO = -power_t'(PCT_FULL);

	// Sequencer states. Arithmetic states issue one operation on entry and
	// leave when the shared unit reports done.
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_GOAL = 9'b000000010,
		S_SET  = 9'b000000100,
		S_LP   = 9'b000001000,
		S_LL   = 9'b000010000,
		S_LR   = 9'b000100000,
		S_DL   = 9'b001000000,
		S_DR   = 9'b010000000,
		S_OUT  = 9'b100000000
	} seq_state_t;

	seq_state_t state_q;
	logic       go_q;

	// Committed values, ramp targets and ramp progress.
	power_t base_power_q;
	mult_t  base_left_q;
	mult_t  base_right_q;
	power_t goal_power_q;
	mult_t  goal_left_q;
	mult_t  goal_right_q;
	ticks_t ramp_length_q;
	ticks_t elapsed_q;
	logic   active_q;

	// Per-word working values.
	ticks_t dur_q;
	mult_t  speed_q;
	logic   rej_q;
	power_t p_q;
	mult_t  l_q;
	mult_t  r_q;
	power_t dl_q;
	power_t dr_q;

	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	// Input decode.
	logic   accept;
	cmd_t   cmd_in;
	power_t amt;
	ticks_t dur_in;
	power_t power_in;
	mult_t  speed_in;
	logic   is_move;
	logic   is_turn;
	logic   out_load;

	// Shared unit operands.
	logic signed [AW-1:0]     md_a;
	logic signed [BW-1:0]     md_b;
	logic [DW-1:0]            md_d;
	logic                     md_done;
	logic signed [RW-1:0]     md_q;
	logic signed [PWR_W:0]    diff_p;
	logic signed [MULT_W:0]   diff_l;
	logic signed [MULT_W:0]   diff_r;
	power_t                   goal_sat;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cmd_in   = (s_tuser > CMD_STOP) ? CMD_STOP : s_tuser;
	assign amt      = $signed(s_tdata[PWR_W-1:0]);
	assign dur_in   = s_tdata[PWR_W+TIME_W-1:PWR_W];
	assign is_move  = (cmd_in != CMD_TICK) && (cmd_in != CMD_STOP);
	assign is_turn  = (cmd_in == CMD_LEFT) || (cmd_in == CMD_RIGHT);
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		if (amt > PWR_HI) begin
			power_in = PWR_HI;
		end else if (amt < PWR_LO) begin
			power_in = PWR_LO;
		end else begin
			power_in = amt;
		end
		if (amt > SPD_HI) begin
			speed_in = MULT_FWD;
		end else if (amt < SPD_LO) begin
			speed_in = MULT_REV;
		end else begin
			speed_in = mult_t'(amt);
		end
	end

	assign diff_p = (PWR_W+1)'(goal_power_q) - (PWR_W+1)'(base_power_q);
	assign diff_l = (MULT_W+1)'(goal_left_q) - (MULT_W+1)'(base_left_q);
	assign diff_r = (MULT_W+1)'(goal_right_q) - (MULT_W+1)'(base_right_q);

	// Turn from standstill: power goal is FULL_POWER * speed / 100, limited.
	always_comb begin
		if (md_q > Q_HI) begin
			goal_sat = DRIVE_HI;
		end else if (md_q < Q_LO) begin
			goal_sat = DRIVE_LO;
		end else begin
			goal_sat = power_t'(md_q);
		end
	end

	// Interpolation is diff * elapsed / ramp_length; drives are p * m / 100.
	always_comb begin
		case (state_q)
			S_GOAL: begin
				md_a = AW'(FULL_POWER);
				md_b = BW'(speed_q);
				md_d = DW'(PCT_FULL);
			end
			S_LP: begin
				md_a = AW'(diff_p);
				md_b = $signed({1'b0, elapsed_q});
				md_d = ramp_length_q;
			end
			S_LL: begin
				md_a = AW'(diff_l);
				md_b = $signed({1'b0, elapsed_q});
				md_d = ramp_length_q;
			end
			S_LR: begin
				md_a = AW'(diff_r);
				md_b = $signed({1'b0, elapsed_q});
				md_d = ramp_length_q;
			end
			S_DL: begin
				md_a = AW'(p_q);
				md_b = BW'(l_q);
				md_d = DW'(PCT_FULL);
			end
			S_DR: begin
				md_a = AW'(p_q);
				md_b = BW'(r_q);
				md_d = DW'(PCT_FULL);
			end
			default: begin
				md_a = '0;
				md_b = '0;
				md_d = '0;
			end
		endcase
	end

	ddr_muldiv #(
		.AW(AW),
		.BW(BW),
		.DW(DW),
		.QW(QW)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.a      (md_a),
		.b      (md_b),
		.d      (md_d),
		.done   (md_done),
		.q      (md_q)
	);

	// Sequencer and ramp state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			go_q          <= 1'b0;
			m_tvalid_q    <= 1'b0;
			base_power_q  <= '0;
			base_left_q   <= MULT_FWD;
			base_right_q  <= MULT_FWD;
			goal_power_q  <= '0;
			goal_left_q   <= MULT_FWD;
			goal_right_q  <= MULT_FWD;
			ramp_length_q <= '0;
			elapsed_q     <= '0;
			active_q      <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd_in == CMD_STOP) begin
							active_q     <= 1'b0;
							base_power_q <= '0;
							goal_power_q <= '0;
							goal_left_q  <= base_left_q;
							goal_right_q <= base_right_q;
							elapsed_q    <= '0;
							state_q      <= S_OUT;
						end else if (cmd_in == CMD_TICK) begin
							go_q <= 1'b1;
							if (active_q) begin
								elapsed_q <= elapsed_q + 1'b1;
								state_q   <= S_LP;
							end else begin
								state_q <= S_DL;
							end
						end else if (active_q) begin
							// A move during a ramp is refused; show where the ramp is.
							go_q    <= 1'b1;
							state_q <= S_LP;
						end else begin
							case (cmd_in)
								CMD_FWD: begin
									goal_power_q <= power_in;
									goal_left_q  <= MULT_FWD;
									goal_right_q <= MULT_FWD;
								end
								CMD_BACK: begin
									goal_power_q <= -power_in;
									goal_left_q  <= MULT_FWD;
									goal_right_q <= MULT_FWD;
								end
								CMD_LEFT: begin
									if (base_power_q == '0) begin
										goal_left_q  <= MULT_REV;
										goal_right_q <= MULT_FWD;
									end else begin
										goal_power_q <= base_power_q;
										goal_left_q  <= speed_in;
										goal_right_q <= MULT_FWD;
									end
								end
								CMD_RIGHT: begin
									if (base_power_q == '0) begin
										goal_left_q  <= MULT_FWD;
										goal_right_q <= MULT_REV;
									end else begin
										goal_power_q <= base_power_q;
										goal_left_q  <= MULT_FWD;
										goal_right_q <= speed_in;
									end
								end
								default: begin
									goal_power_q <= '0;
									goal_left_q  <= base_left_q;
									goal_right_q <= base_right_q;
								end
							endcase
							if (is_turn && base_power_q == '0) begin
								go_q    <= 1'b1;
								state_q <= S_GOAL;
							end else begin
								state_q <= S_SET;
							end
						end
					end
				end
				S_GOAL: begin
					if (md_done) begin
						goal_power_q <= goal_sat;
						state_q      <= S_SET;
					end
				end
				S_SET: begin
					// Start the ramp; a zero duration commits the goals at once.
					ramp_length_q <= dur_q;
					elapsed_q     <= '0;
					active_q      <= (dur_q != '0);
					if (dur_q == '0) begin
						base_power_q <= goal_power_q;
						base_left_q  <= goal_left_q;
						base_right_q <= goal_right_q;
					end
					go_q    <= 1'b1;
					state_q <= S_DL;
				end
				S_LP: begin
					if (md_done) begin
						go_q    <= 1'b1;
						state_q <= S_LL;
					end
				end
				S_LL: begin
					if (md_done) begin
						go_q    <= 1'b1;
						state_q <= S_LR;
					end
				end
				S_LR: begin
					if (md_done) begin
						// End of ramp: the goals become the committed values.
						if (elapsed_q == ramp_length_q) begin
							base_power_q <= goal_power_q;
							base_left_q  <= goal_left_q;
							base_right_q <= goal_right_q;
							active_q     <= 1'b0;
						end
						go_q    <= 1'b1;
						state_q <= S_DL;
					end
				end
				S_DL: begin
					if (md_done) begin
						go_q    <= 1'b1;
						state_q <= S_DR;
					end
				end
				S_DR: begin
					if (md_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working values and the output word.
	always_ff @(posedge clk) begin
		if (accept) begin
			dur_q   <= dur_in;
			speed_q <= speed_in;
			rej_q   <= is_move && active_q;
			if (cmd_in == CMD_STOP) begin
				dl_q <= '0;
				dr_q <= '0;
			end
			p_q <= base_power_q;
			l_q <= base_left_q;
			r_q <= base_right_q;
		end
		if (state_q == S_SET) begin
			if (dur_q == '0) begin
				p_q <= goal_power_q;
				l_q <= goal_left_q;
				r_q <= goal_right_q;
			end else begin
				p_q <= base_power_q;
				l_q <= base_left_q;
				r_q <= base_right_q;
			end
		end
		if (md_done) begin
			case (state_q)
				S_LP: p_q <= base_power_q + power_t'(md_q);
				S_LL: l_q <= base_left_q + mult_t'(md_q);
				S_LR: r_q <= base_right_q + mult_t'(md_q);
				S_DL: dl_q <= power_t'(md_q);
				S_DR: dr_q <= power_t'(md_q);
				default: begin
				end
			endcase
		end
		if (out_load) begin
			m_tdata_q <= {2'b00, dr_q, dl_q};
			m_tuser_q <= {rej_q, active_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// A live ramp always has a nonzero length.
	a_ramp_len: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ramp_length_q != '0)
		else $error("ramp active with zero length");

	// Between words a live ramp has not yet reached its end.
	a_ramp_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && active_q) |-> elapsed_q < ramp_length_q)
		else $error("ramp left open at its end");

	// The shared unit only finishes work that an arithmetic state asked for.
	a_done_owner: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == S_GOAL || state_q == S_LP || state_q == S_LL ||
			state_q == S_LR || state_q == S_DL || state_q == S_DR))
		else $error("arithmetic result with no requester");

	// A new operation is never issued while a result is being returned.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> !md_done)
		else $error("operation issued while unit busy");

	// A finished word waiting on a free output register is loaded next cycle.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !m_tvalid_q) |=> m_tvalid_q)
		else $error("result word not loaded");

endmodule
